[sv/lcb_pkg.sv]
// Shared types and constants of the LRU cache with byte budget.
package lcb_pkg;

  localparam int unsigned KeyW        = 32;
  localparam int unsigned HandleW     = 16;
  localparam int unsigned DimW        = 10;
  localparam int unsigned ByteW       = 30;
  localparam int unsigned EntryByteW  = 22;
  localparam int unsigned CountOutW   = 10;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [9:0]       EntryCapReset = 10'd384;
  localparam logic [ByteW-1:0] ByteCapReset  = 30'd100663296;
  localparam logic [9:0]       DimLimitReset = 10'd512;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENTRY_CAP = 2'd0,
    CFG_BYTE_CAP  = 2'd1,
    CFG_DIM_LIMIT = 2'd2
  } lcb_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_INSERTED = 2'd1,
    ST_MISS     = 2'd2,
    ST_REJECT   = 2'd3
  } lcb_status_e;

  typedef enum logic [1:0] {
    CMD_LOOKUP,
    CMD_INSERT,
    CMD_REJECT
  } lcb_kind_e;

  typedef struct packed {
    logic               opcode;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle_in;
    logic [DimW-1:0]    width_in;
    logic [DimW-1:0]    height_in;
  } lcb_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [HandleW-1:0]   handle_out;
    logic [DimW-1:0]      width_out;
    logic [DimW-1:0]      height_out;
    logic [CountOutW-1:0] evicted_count;
    logic [ByteW-1:0]     bytes_in_use;
    logic [CountOutW-1:0] entries_in_use;
  } lcb_res_t;

  typedef struct packed {
    logic [9:0]       entry_cap;
    logic [ByteW-1:0] byte_cap;
    logic [9:0]       dim_limit;
  } lcb_cfg_t;

  // Classified command passed from front to back
  typedef struct packed {
    lcb_kind_e             kind;
    logic [KeyW-1:0]       key;
    logic [HandleW-1:0]    handle;
    logic [DimW-1:0]       width;
    logic [DimW-1:0]       height;
    logic [EntryByteW-1:0] nbytes;
  } lcb_cmd_t;

  // Payload of one cache slot
  typedef struct packed {
    logic [KeyW-1:0]       key;
    logic [HandleW-1:0]    handle;
    logic [DimW-1:0]       width;
    logic [DimW-1:0]       height;
    logic [EntryByteW-1:0] nbytes;
  } lcb_entry_t;

endpackage

[sv/lcb_front.sv]
// Front end: classifies each accepted request and sizes its image.
module lcb_front import lcb_pkg::*; (
  input  lcb_req_t req_i,
  input  lcb_cfg_t cfg_i,
  output lcb_cmd_t cmd_o
);

  logic                  bad_size;
  logic [2*DimW-1:0]     area;

  // Reject zero or oversized dimensions on insert
  assign bad_size = (req_i.width_in == '0) || (req_i.height_in == '0) ||
                    (req_i.width_in > cfg_i.dim_limit) ||
                    (req_i.height_in > cfg_i.dim_limit);

  assign area = req_i.width_in * req_i.height_in;

  always_comb begin
    cmd_o.key    = req_i.key;
    cmd_o.handle = req_i.handle_in;
    cmd_o.width  = req_i.width_in;
    cmd_o.height = req_i.height_in;
    cmd_o.nbytes = {area, 2'b00};
    if (!req_i.opcode) begin
      cmd_o.kind = CMD_LOOKUP;
    end else if (bad_size) begin
      cmd_o.kind = CMD_REJECT;
    end else begin
      cmd_o.kind = CMD_INSERT;
    end
  end

endmodule

[sv/lcb_fifo.sv]
// Short command queue between front and back.
module lcb_fifo import lcb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lcb_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output lcb_cmd_t pop_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  lcb_cmd_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[sv/lcb_back.sv]
// Back end: list walk, LRU relinking, eviction and insertion.
module lcb_back import lcb_pkg::*; #(
  parameter int unsigned CAPACITY = 512
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lcb_cfg_t cfg_i,
  input  logic     cmd_valid_i,
  input  lcb_cmd_t cmd_i,
  output logic     cmd_pop_o,
  output logic     result_valid_o,
  output lcb_res_t result_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_HIT_UNLINK,
    S_HIT_FRONT,
    S_EVICT_CHECK,
    S_EVICT,
    S_ALLOC,
    S_ALLOC_WAIT,
    S_INSERT,
    S_RESP
  } state_e;

  // Slot storage and list links
  lcb_entry_t    data_mem [CAPACITY];
  logic [IW-1:0] next_mem [CAPACITY];
  logic [IW-1:0] prev_mem [CAPACITY];
  logic [IW-1:0] free_mem [CAPACITY];

  state_e        state_q;
  lcb_cmd_t      cmd_q;
  logic [IW-1:0] head_q, tail_q, cur_q, prv_q, nxt_q, slot_q;
  logic [CW-1:0] count_q, steps_q, sp_q, fill_q, evicted_q;
  logic [ByteW-1:0] bytes_q;
  lcb_status_e   status_q;
  logic [HandleW-1:0] res_handle_q;
  logic [DimW-1:0]    res_width_q, res_height_q;
  logic          result_valid_q;
  lcb_res_t      result_q;

  // Memory ports
  logic [IW-1:0] rd_addr;
  lcb_entry_t    data_rd;
  logic [IW-1:0] next_rd, prev_rd, free_rd, free_raddr;
  logic          data_we, next_we, prev_we, free_we;
  logic [IW-1:0] data_wa, next_wa, next_wd, prev_wa, prev_wd, free_wa, free_wd;
  lcb_entry_t    data_wd;

  logic [31:0]   cap_eff;
  logic          over_count, over_bytes, must_evict, key_match;

  assign cmd_pop_o      = (state_q == S_IDLE) && cmd_valid_i;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // Eviction test against both caps
  assign cap_eff    = (32'(cfg_i.entry_cap) < 32'(CAPACITY)) ?
                      32'(cfg_i.entry_cap) : 32'(CAPACITY);
  assign over_count = (32'(count_q) + 32'd1) > cap_eff;
  assign over_bytes = ({1'b0, bytes_q} + (ByteW+1)'(cmd_q.nbytes)) >
                      (ByteW+1)'(cfg_i.byte_cap);
  assign must_evict = (count_q != '0) && (over_count || over_bytes);
  assign key_match  = (data_rd.key == cmd_q.key);

  // Select read address and memory writes
  always_comb begin
    rd_addr    = head_q;
    free_raddr = IW'(sp_q - 1'b1);
    data_we = 1'b0; data_wa = slot_q;
    data_wd = '{key: cmd_q.key, handle: cmd_q.handle, width: cmd_q.width,
                height: cmd_q.height, nbytes: cmd_q.nbytes};
    next_we = 1'b0; next_wa = slot_q; next_wd = head_q;
    prev_we = 1'b0; prev_wa = head_q; prev_wd = slot_q;
    free_we = 1'b0; free_wa = IW'(sp_q); free_wd = tail_q;
    case (state_q)
      S_SEARCH: begin
        rd_addr = next_rd;
      end
      S_EVICT_CHECK: begin
        rd_addr = tail_q;
      end
      S_EVICT: begin
        free_we = 1'b1;
      end
      S_HIT_UNLINK: begin
        next_we = 1'b1; next_wa = prv_q; next_wd = nxt_q;
        prev_we = (cur_q != tail_q); prev_wa = nxt_q; prev_wd = prv_q;
      end
      S_HIT_FRONT: begin
        next_we = 1'b1; next_wa = cur_q; next_wd = head_q;
        prev_we = 1'b1; prev_wa = head_q; prev_wd = cur_q;
      end
      S_INSERT: begin
        data_we = 1'b1;
        next_we = 1'b1;
        prev_we = (count_q != '0);
      end
      default: begin
      end
    endcase
  end

  // Read and write slot storage
  always_ff @(posedge clk_i) begin
    if (data_we) data_mem[data_wa] <= data_wd;
    data_rd <= data_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[rd_addr];
  end

  // Stack of released slots
  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd <= free_mem[free_raddr];
  end

  // Sequence each command and hold the result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      head_q         <= '0;
      tail_q         <= '0;
      count_q        <= '0;
      bytes_q        <= '0;
      sp_q           <= '0;
      fill_q         <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q        <= cmd_i;
            evicted_q    <= '0;
            res_handle_q <= '0;
            res_width_q  <= '0;
            res_height_q <= '0;
            cur_q        <= head_q;
            steps_q      <= CW'(1);
            if (cmd_i.kind == CMD_REJECT) begin
              status_q <= ST_REJECT;
              state_q  <= S_RESP;
            end else if (count_q == '0) begin
              status_q <= ST_MISS;
              state_q  <= (cmd_i.kind == CMD_INSERT) ? S_EVICT_CHECK : S_RESP;
            end else begin
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (key_match) begin
            status_q     <= ST_HIT;
            res_handle_q <= data_rd.handle;
            res_width_q  <= data_rd.width;
            res_height_q <= data_rd.height;
            prv_q        <= prev_rd;
            nxt_q        <= next_rd;
            state_q      <= (cur_q == head_q) ? S_RESP : S_HIT_UNLINK;
          end else if (steps_q == count_q) begin
            status_q <= ST_MISS;
            state_q  <= (cmd_q.kind == CMD_INSERT) ? S_EVICT_CHECK : S_RESP;
          end else begin
            cur_q   <= next_rd;
            steps_q <= steps_q + 1'b1;
          end
        end
        S_HIT_UNLINK: begin
          if (cur_q == tail_q) begin
            tail_q <= prv_q;
          end
          state_q <= S_HIT_FRONT;
        end
        S_HIT_FRONT: begin
          head_q  <= cur_q;
          state_q <= S_RESP;
        end
        S_EVICT_CHECK: begin
          state_q <= must_evict ? S_EVICT : S_ALLOC;
        end
        S_EVICT: begin
          // Drop the tail entry
          sp_q      <= sp_q + 1'b1;
          bytes_q   <= bytes_q - ByteW'(data_rd.nbytes);
          count_q   <= count_q - 1'b1;
          tail_q    <= prev_rd;
          evicted_q <= evicted_q + 1'b1;
          state_q   <= S_EVICT_CHECK;
        end
        S_ALLOC: begin
          if (sp_q != '0) begin
            sp_q    <= sp_q - 1'b1;
            state_q <= S_ALLOC_WAIT;
          end else begin
            slot_q  <= fill_q[IW-1:0];
            fill_q  <= fill_q + 1'b1;
            state_q <= S_INSERT;
          end
        end
        S_ALLOC_WAIT: begin
          slot_q  <= free_rd;
          state_q <= S_INSERT;
        end
        S_INSERT: begin
          if (count_q == '0) begin
            tail_q <= slot_q;
          end
          head_q       <= slot_q;
          count_q      <= count_q + 1'b1;
          bytes_q      <= bytes_q + ByteW'(cmd_q.nbytes);
          status_q     <= ST_INSERTED;
          res_handle_q <= cmd_q.handle;
          res_width_q  <= cmd_q.width;
          res_height_q <= cmd_q.height;
          state_q      <= S_RESP;
        end
        S_RESP: begin
          result_q.status         <= status_q;
          result_q.handle_out     <= res_handle_q;
          result_q.width_out      <= res_width_q;
          result_q.height_out     <= res_height_q;
          result_q.evicted_count  <= CountOutW'(evicted_q);
          result_q.bytes_in_use   <= bytes_q;
          result_q.entries_in_use <= CountOutW'(count_q);
          result_valid_q          <= 1'b1;
          state_q                 <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/lru_cache_with_byte_budget.sv]
// Top level of the LRU cache with entry cap and byte budget.
// A request is taken when start is high and busy is low; up to two requests
// queue ahead of the engine. Each request yields one result, shown for one
// cycle with result_valid_o; results cannot be held off. The back end walks
// the linked list one entry per cycle from most to least recent; a hit not
// already at the front is relinked there, least recent entries are evicted
// until an insert fits, and a rejected request skips the walk. No clearing
// pass after reset.
module lru_cache_with_byte_budget import lcb_pkg::*; #(
  parameter int unsigned CAPACITY = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  lcb_req_t           req_i,
  output logic               result_valid_o,
  output lcb_res_t           result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

  lcb_cfg_t cfg_q;
  lcb_cmd_t front_cmd, queue_cmd;
  logic     queue_full, queue_valid, queue_pop, accept;

  assign cfg_ready_o = 1'b1;
  assign busy        = queue_full;
  assign accept      = start && !busy;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry_cap <= EntryCapReset;
      cfg_q.byte_cap  <= ByteCapReset;
      cfg_q.dim_limit <= DimLimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ENTRY_CAP: cfg_q.entry_cap <= cfg_data_i[9:0];
        CFG_BYTE_CAP:  cfg_q.byte_cap  <= cfg_data_i;
        CFG_DIM_LIMIT: cfg_q.dim_limit <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  lcb_front u_front (
    .req_i (req_i),
    .cfg_i (cfg_q),
    .cmd_o (front_cmd)
  );

  lcb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_cmd)
  );

  lcb_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_valid_i    (queue_valid),
    .cmd_i          (queue_cmd),
    .cmd_pop_o      (queue_pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

[sim/lru_cache_with_byte_budget_test.sv]
// Self-checking testbench for the LRU cache with entry cap and byte budget.
module lru_cache_with_byte_budget_test;
  import lcb_pkg::*;

  localparam int unsigned Slots     = 512;
  localparam int unsigned CycleCap  = 10_000_000;
  localparam logic        OP_LOOKUP = 1'b0;
  localparam logic        OP_INSERT = 1'b1;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  lcb_req_t           req_i = '0;
  logic               result_valid_o;
  lcb_res_t           result_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_ENTRY_CAP;
  logic [ByteW-1:0]   cfg_data_i = '0;

  lru_cache_with_byte_budget u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the cache contents and registers
  logic [KeyW-1:0]    sh_key    [Slots];
  logic               sh_valid  [Slots];
  logic [HandleW-1:0] sh_handle [Slots];
  logic [DimW-1:0]    sh_width  [Slots];
  logic [DimW-1:0]    sh_height [Slots];
  int unsigned        sh_rank   [Slots];
  longint unsigned    sh_bytes;
  int unsigned        sh_count;
  int unsigned        reg_entry_cap = EntryCapReset;
  longint unsigned    reg_byte_cap  = ByteCapReset;
  int unsigned        reg_dim_limit = DimLimitReset;

  lcb_res_t    pending_results[$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned hits = 0, inserts = 0, misses = 0, rejects = 0, evictions = 0;

  // Work out the result of one request and advance the shadow state
  task automatic cache_step(input lcb_req_t r, output lcb_res_t o);
    int slot;
    int free_slot;
    int unsigned cap;
    int unsigned rk;
    int unsigned ev;
    longint unsigned inc;
    o = '0;
    ev = 0;
    if (r.opcode == OP_INSERT && (r.width_in == 0 || r.height_in == 0 ||
        r.width_in > reg_dim_limit || r.height_in > reg_dim_limit)) begin
      o.status = ST_REJECT;
    end else begin
      slot = -1;
      for (int i = 0; i < Slots; i++) begin
        if (sh_valid[i] && sh_key[i] == r.key) begin
          slot = i;
          break;
        end
      end
      if (slot >= 0) begin
        rk = sh_rank[slot];
        for (int i = 0; i < Slots; i++)
          if (sh_valid[i] && sh_rank[i] < rk) sh_rank[i]++;
        sh_rank[slot] = 0;
        o.status = ST_HIT;
        o.handle_out = sh_handle[slot];
        o.width_out = sh_width[slot];
        o.height_out = sh_height[slot];
      end else if (r.opcode == OP_LOOKUP) begin
        o.status = ST_MISS;
      end else begin
        inc = longint'(r.width_in) * longint'(r.height_in) * 4;
        cap = (reg_entry_cap < Slots) ? reg_entry_cap : Slots;
        // Drop least recent entries until the new one fits
        while (sh_count > 0 && (sh_count + 1 > cap || sh_bytes + inc > reg_byte_cap)) begin
          for (int i = 0; i < Slots; i++) begin
            if (sh_valid[i] && sh_rank[i] + 1 == sh_count) begin
              sh_valid[i] = 1'b0;
              sh_bytes -= longint'(sh_width[i]) * longint'(sh_height[i]) * 4;
              sh_count--;
              break;
            end
          end
          ev++;
        end
        free_slot = -1;
        for (int i = 0; i < Slots; i++) begin
          if (sh_valid[i]) sh_rank[i]++;
          else if (free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) free_slot = 0;
        sh_valid[free_slot] = 1'b1;
        sh_key[free_slot] = r.key;
        sh_handle[free_slot] = r.handle_in;
        sh_width[free_slot] = r.width_in;
        sh_height[free_slot] = r.height_in;
        sh_rank[free_slot] = 0;
        sh_count++;
        sh_bytes += inc;
        o.status = ST_INSERTED;
        o.handle_out = r.handle_in;
        o.width_out = r.width_in;
        o.height_out = r.height_in;
      end
    end
    o.evicted_count = ev[CountOutW-1:0];
    o.bytes_in_use = sh_bytes[ByteW-1:0];
    o.entries_in_use = sh_count[CountOutW-1:0];
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, field, got, want);
    fail_count++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report(field, got, want);
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    lcb_res_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected result, status", 32'(result_o.status), 32'hffff_ffff);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(result_o.status), 32'(want.status));
        check_field("handle_out", 32'(result_o.handle_out), 32'(want.handle_out));
        check_field("width_out", 32'(result_o.width_out), 32'(want.width_out));
        check_field("height_out", 32'(result_o.height_out), 32'(want.height_out));
        check_field("evicted_count", 32'(result_o.evicted_count), 32'(want.evicted_count));
        check_field("bytes_in_use", 32'(result_o.bytes_in_use), 32'(want.bytes_in_use));
        check_field("entries_in_use", 32'(result_o.entries_in_use),
                    32'(want.entries_in_use));
        case (want.status)
          ST_HIT:      hits++;
          ST_INSERTED: inserts++;
          ST_MISS:     misses++;
          default:     rejects++;
        endcase
        evictions += want.evicted_count;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleCap) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Hand one request over; typed expectation is used when has_want is set
  task automatic send(input lcb_req_t r, input bit has_want, input lcb_res_t want);
    lcb_res_t predicted;
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    cache_step(r, predicted);
    if (has_want) predicted = want;
    pending_results.insert(pending_results.size(), predicted);
    @(negedge clk_i);
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one register while the cache is idle
  task automatic write_reg(input lcb_cfg_idx_e idx, input logic [ByteW-1:0] data);
    drain();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ENTRY_CAP: reg_entry_cap = data[9:0];
      CFG_BYTE_CAP:  reg_byte_cap = data;
      default:       reg_dim_limit = data[9:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(input int unsigned ecap, input int unsigned bcap,
                           input int unsigned dlim);
    write_reg(CFG_ENTRY_CAP, ByteW'(ecap));
    write_reg(CFG_BYTE_CAP, ByteW'(bcap));
    write_reg(CFG_DIM_LIMIT, ByteW'(dlim));
  endtask

  // Random requests over a small key pool, with a few wild keys and bad sizes
  task automatic random_burst(input int unsigned n, input int unsigned pool,
                              input int unsigned max_dim);
    lcb_req_t r;
    int unsigned lim;
    for (int i = 0; i < n; i++) begin
      r.opcode = ($urandom_range(99) < 65) ? OP_INSERT : OP_LOOKUP;
      r.key = ($urandom_range(9) == 0) ? $urandom : 32'h4000_0000 + $urandom_range(pool - 1);
      r.handle_in = $urandom;
      lim = (reg_dim_limit < max_dim) ? reg_dim_limit : max_dim;
      if (lim == 0) lim = 1;
      if ($urandom_range(99) < 85) begin
        r.width_in = $urandom_range(1, lim);
        r.height_in = $urandom_range(1, lim);
      end else begin
        r.width_in = ($urandom_range(1) == 0) ? 10'd0 : 10'($urandom);
        r.height_in = 10'($urandom);
      end
      send(r, 1'b0, '0);
    end
  endtask

  typedef struct {
    lcb_req_t req;
    bit       has_want;
    lcb_res_t want;
  } stim_row_t;

  stim_row_t rows[14];

  initial begin
    lcb_req_t r;
    for (int i = 0; i < Slots; i++) begin
      sh_valid[i] = 1'b0;
      sh_rank[i] = 0;
    end
    sh_bytes = 0;
    sh_count = 0;

    // Directed rows under reset settings
    rows[0]  = '{'{OP_LOOKUP, 32'h0, 16'h0, 10'd0, 10'd0}, 1,
                 '{ST_MISS, 16'h0, 10'd0, 10'd0, 10'd0, 30'd0, 10'd0}};
    rows[1]  = '{'{OP_INSERT, 32'h0, 16'h1, 10'd0, 10'd5}, 1,
                 '{ST_REJECT, 16'h0, 10'd0, 10'd0, 10'd0, 30'd0, 10'd0}};
    rows[2]  = '{'{OP_INSERT, 32'h0, 16'h1, 10'd5, 10'd0}, 1,
                 '{ST_REJECT, 16'h0, 10'd0, 10'd0, 10'd0, 30'd0, 10'd0}};
    rows[3]  = '{'{OP_INSERT, 32'h0, 16'h1, 10'd513, 10'd1}, 1,
                 '{ST_REJECT, 16'h0, 10'd0, 10'd0, 10'd0, 30'd0, 10'd0}};
    rows[4]  = '{'{OP_INSERT, 32'h0, 16'h1, 10'd1, 10'd1023}, 1,
                 '{ST_REJECT, 16'h0, 10'd0, 10'd0, 10'd0, 30'd0, 10'd0}};
    rows[5]  = '{'{OP_INSERT, 32'h0, 16'hffff, 10'd1, 10'd1}, 1,
                 '{ST_INSERTED, 16'hffff, 10'd1, 10'd1, 10'd0, 30'd4, 10'd1}};
    rows[6]  = '{'{OP_INSERT, 32'hffff_ffff, 16'h0, 10'd512, 10'd512}, 1,
                 '{ST_INSERTED, 16'h0, 10'd512, 10'd512, 10'd0, 30'd1048580, 10'd2}};
    rows[7]  = '{'{OP_LOOKUP, 32'h0, 16'h0, 10'd0, 10'd0}, 0, '0};
    rows[8]  = '{'{OP_INSERT, 32'hffff_ffff, 16'h1234, 10'd1, 10'd1}, 0, '0};
    rows[9]  = '{'{OP_INSERT, 32'h0, 16'h0, 10'd0, 10'd1}, 0, '0};
    rows[10] = '{'{OP_LOOKUP, 32'h1234_5678, 16'h0, 10'd0, 10'd0}, 0, '0};
    rows[11] = '{'{OP_INSERT, 32'h5555_aaaa, 16'haaaa, 10'd511, 10'd3}, 0, '0};
    rows[12] = '{'{OP_INSERT, 32'haaaa_5555, 16'h5555, 10'd3, 10'd511}, 0, '0};
    rows[13] = '{'{OP_LOOKUP, 32'hffff_ffff, 16'h0, 10'd0, 10'd0}, 0, '0};

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Sender idles often at first
    idle_pct = 22;
    foreach (rows[i]) send(rows[i].req, rows[i].has_want, rows[i].want);

    configure(8, 1 << 20, 64);
    random_burst(150, 16, 64);

    // Zero entry cap empties the cache on every insert miss
    configure(0, 536870912, 1023);
    random_burst(80, 8, 1023);

    // Cap above the slot count: fill every slot, then push past it
    idle_pct = 62;
    configure(1023, 536870912, 1023);
    for (int i = 0; i < Slots + 8; i++) begin
      r = '{OP_INSERT, 32'h8000_0000 + i, 16'($urandom), 10'd1, 10'd1};
      send(r, 1'b0, '0);
    end
    for (int i = 0; i < 40; i++) begin
      r = '{OP_LOOKUP, 32'h8000_0000 + $urandom_range(Slots + 7), 16'h0, 10'd0, 10'd0};
      send(r, 1'b0, '0);
    end

    // Smallest byte budget and dimension limit: oversized single entries
    configure(512, 4, 1);
    random_burst(80, 6, 1);
    write_reg(CFG_DIM_LIMIT, ByteW'(1023));
    random_burst(60, 6, 1023);

    // No idling from here on
    idle_pct = 0;
    configure(1, 100000, 100);
    random_burst(120, 8, 100);
    configure(12, 3000000, 1023);
    random_burst(150, 24, 300);
    configure(384, 100663296, 512);
    random_burst(150, 32, 512);

    drain();
    repeat (50) @(negedge clk_i);
    $display("checked %0d results: %0d hits, %0d inserts, %0d misses, %0d rejects",
             results_seen, hits, inserts, misses, rejects);
    $display("%0d entries evicted over several cap and budget settings", evictions);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/lcb_pkg.sv
sv/lcb_front.sv
sv/lcb_fifo.sv
sv/lcb_back.sv
sv/lru_cache_with_byte_budget.sv
sim/lru_cache_with_byte_budget_test.sv
